FILE: design/agc_pkg.sv
// Shared types, constants and sine table builder for the gravity compensation block.
package agc_pkg;

  localparam int FRACTION_BITS    = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int RATE_BITS        = 16;
  localparam int QDEPTH           = 2;

  localparam logic signed [63:0] FIX_ONE      = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] SMALL_005    = ((64'sd5 <<< FRACTION_BITS) + 64'sd50) / 64'sd100;
  localparam logic signed [63:0] REF_DEADBAND =
    ((64'sd34906585 <<< FRACTION_BITS) + 64'sd500000000) / 64'sd1000000000;
  localparam logic signed [32:0] TURN_PER_RAD = 33'sd683565276;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_MODEL_LIMIT   = 1'b1;

  typedef struct packed {
    logic               fresh;
    logic        [31:0] feedback_time;
    logic signed [31:0] actual_angle;
    logic signed [31:0] actual_speed;
    logic signed [31:0] measured_torque;
    logic signed [31:0] desired_angle;
    logic signed [31:0] desired_speed;
    logic signed [31:0] request_torque;
    logic signed [31:0] limit_torque;
  } item_t;

  // Queue entry: the item plus the front end's classification.
  typedef struct packed {
    item_t item;
    logic  no_drive;
  } qitem_t;

  typedef logic signed [31:0] rom_t [SINE_TABLE_DEPTH];

  function automatic logic signed [31:0] rom_entry(input logic [63:0] k);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [1:0]  q;
    p = (k << 32) / SINE_TABLE_DEPTH;
    q = p[31:30];
    r = p & (ONE_Q30 - 64'd1);
    if (q[0]) begin
      r = ONE_Q30 - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - ((x2 * ONE_Q30) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (((x * t) >> 30) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    return q[1] ? -s[31:0] : s[31:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = rom_entry(64'(k));
    end
    return rom;
  endfunction

  // Symmetric saturation to +-lim, lim not negative.
  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] lim);
    logic signed [63:0] res;
    res = v;
    if (v < -lim) begin
      res = -lim;
    end else if (v > lim) begin
      res = lim;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

FILE: design/agc_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module agc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  agc_pkg::item_t  in_item,
  output logic            q_valid,
  input  logic            q_pop,
  output agc_pkg::qitem_t q_head
);
  import agc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  qitem_t           mem_r [QDEPTH];
  logic [PW-1:0]    wr_r;
  logic [PW-1:0]    rd_r;
  logic [PW:0]      cnt_r;
  logic             push;
  logic             pop;

  assign in_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r].item     <= in_item;
      // A non-positive torque limit means a zero result and no state change.
      mem_r[wr_r].no_drive <= (in_item.limit_torque <= 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: design/agc_back.sv
// Back end: sequencer with one shared multiplier that learns and evaluates the model.
module agc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  agc_pkg::qitem_t    q_head,
  input  logic        [16:0] learning_rate,
  input  logic        [30:0] model_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic signed [31:0] out_grav
);
  import agc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_PH   = 5'd2;
  localparam logic [4:0] S_ROM  = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_EST  = 5'd6;
  localparam logic [4:0] S_LCHK = 5'd7;
  localparam logic [4:0] S_LC1  = 5'd8;
  localparam logic [4:0] S_LC2  = 5'd9;
  localparam logic [4:0] S_LC3  = 5'd10;
  localparam logic [4:0] S_LC4  = 5'd11;
  localparam logic [4:0] S_LS1  = 5'd12;
  localparam logic [4:0] S_LS2  = 5'd13;
  localparam logic [4:0] S_LS3  = 5'd14;
  localparam logic [4:0] S_LS4  = 5'd15;
  localparam logic [4:0] S_G1   = 5'd16;
  localparam logic [4:0] S_G2   = 5'd17;
  localparam logic [4:0] S_G3   = 5'd18;

  localparam rom_t SINE_ROM = build_rom();
  localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [63:0] HALF_R = 64'sd1 <<< (RATE_BITS - 1);

  logic [4:0]         st_r;
  item_t              it_r;
  logic               zero_r;
  logic               learn_r;
  logic               qs_r;
  logic signed [31:0] lim_r;
  logic signed [31:0] gpos_r;
  logic signed [31:0] angle_r;
  logic signed [31:0] c_r;
  logic signed [31:0] s_r;
  logic signed [63:0] p_r;
  logic signed [63:0] acc_r;
  logic signed [35:0] est_r;
  logic signed [35:0] res_r;
  logic signed [35:0] t_r;
  logic signed [37:0] dc_r;
  logic signed [31:0] grav_r;
  logic signed [31:0] reqc_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  logic signed [31:0] ref_r;
  logic               ref_valid_r;
  logic               seen_r;
  logic        [31:0] last_r;
  logic               out_valid_r;
  logic signed [31:0] drive_r;
  logic signed [31:0] grav_out_r;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] mul_p;
  logic [IDX_W-1:0]   idx;
  logic signed [63:0] lim_t;
  logic signed [63:0] lim64;
  logic               ref_move;
  logic signed [31:0] gpos_nxt;
  logic               learn_nxt;
  logic signed [63:0] res_nxt;
  logic signed [63:0] sum_nxt;
  logic signed [63:0] drive_nxt;
  logic               out_free;

  assign mul_p     = mul_a * mul_b;
  assign idx       = p_r[FRACTION_BITS + 31 -: IDX_W];
  assign lim_t     = 64'(it_r.limit_torque);
  assign lim64     = 64'(lim_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign out_grav  = grav_out_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_PH: begin
        mul_a = 36'(angle_r);
        mul_b = TURN_PER_RAD;
      end
      S_M1: begin
        mul_a = 36'(cos_r);
        mul_b = 33'(c_r);
      end
      S_M2: begin
        mul_a = 36'(sin_r);
        mul_b = 33'(s_r);
      end
      S_LC1: begin
        mul_a = res_r;
        mul_b = 33'(c_r);
      end
      S_LS1: begin
        mul_a = res_r;
        mul_b = 33'(s_r);
      end
      S_LC3, S_LS3: begin
        mul_a = t_r;
        mul_b = 33'(signed'({1'b0, learning_rate}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ref_move  = !ref_valid_r ||
                (abs64(64'(it_r.actual_angle) - 64'(ref_r)) >= REF_DEADBAND);
    if (it_r.fresh) begin
      gpos_nxt = ref_move ? it_r.actual_angle : ref_r;
    end else begin
      gpos_nxt = ref_valid_r ? ref_r : it_r.desired_angle;
    end
    learn_nxt = it_r.fresh && (!seen_r || (it_r.feedback_time != last_r));
    res_nxt   = 64'(it_r.measured_torque) - 64'(est_r);
    sum_nxt   = acc_r + p_r + HALF_F;
    drive_nxt = zero_r ? 64'sd0 : sat(64'(reqc_r) + 64'(grav_r), lim_t);
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          it_r   <= q_head.item;
          zero_r <= q_head.no_drive;
        end
      end
      S_DEC: begin
        lim_r   <= (32'(model_limit) < it_r.limit_torque) ? 32'(model_limit)
                                                          : it_r.limit_torque;
        gpos_r  <= gpos_nxt;
        angle_r <= learn_nxt ? it_r.actual_angle : gpos_nxt;
        learn_r <= learn_nxt;
        qs_r    <= (abs64(64'(it_r.actual_speed)) <= SMALL_005) &&
                   (abs64(64'(it_r.desired_speed)) <= SMALL_005) &&
                   (abs64(64'(it_r.desired_angle) - 64'(it_r.actual_angle)) <= FIX_ONE) &&
                   (abs64(64'(it_r.request_torque)) <= SMALL_005) &&
                   (abs64(64'(it_r.measured_torque)) <= lim_t);
        grav_r  <= '0;
        reqc_r  <= '0;
      end
      S_PH: begin
        p_r <= mul_p[63:0];
      end
      S_ROM: begin
        s_r <= SINE_ROM[idx];
        c_r <= SINE_ROM[idx + IDX_W'(SINE_TABLE_DEPTH / 4)];
      end
      S_M1: begin
        p_r <= mul_p[63:0];
      end
      S_M2: begin
        acc_r <= p_r;
        p_r   <= mul_p[63:0];
      end
      S_EST: begin
        est_r <= 36'(sum_nxt >>> FRACTION_BITS);
      end
      S_LCHK: begin
        res_r <= 36'(res_nxt);
        if (!(qs_r && (abs64(res_nxt) >= SMALL_005))) begin
          learn_r <= 1'b0;
          angle_r <= gpos_r;
        end
      end
      S_LC1, S_LC3, S_LS1, S_LS3: begin
        p_r <= mul_p[63:0];
      end
      S_LC2, S_LS2: begin
        t_r <= 36'((p_r + HALF_F) >>> FRACTION_BITS);
      end
      S_LC4: begin
        dc_r <= 38'((p_r + HALF_R) >>> RATE_BITS);
      end
      S_LS4: begin
        learn_r <= 1'b0;
        angle_r <= gpos_r;
      end
      S_G1: begin
        grav_r <= 32'(sat(64'(est_r), lim64));
        reqc_r <= 32'(sat(64'(it_r.request_torque), lim_t));
      end
      S_G2: begin
        grav_r <= 32'(sat(64'(grav_r), lim_t - abs64(64'(reqc_r))));
      end
      S_G3: begin
        if (out_free) begin
          drive_r    <= 32'(drive_nxt);
          grav_out_r <= zero_r ? 32'sd0 : grav_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, learned state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cos_r       <= '0;
      sin_r       <= '0;
      ref_r       <= '0;
      ref_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (zero_r) begin
            st_r <= S_G3;
          end else begin
            if (it_r.fresh && ref_move) begin
              ref_r       <= it_r.actual_angle;
              ref_valid_r <= 1'b1;
            end
            if (learn_nxt) begin
              seen_r <= 1'b1;
              last_r <= it_r.feedback_time;
            end
            st_r <= S_PH;
          end
        end
        S_PH:  st_r <= S_ROM;
        S_ROM: st_r <= S_M1;
        S_M1:  st_r <= S_M2;
        S_M2:  st_r <= S_EST;
        S_EST: st_r <= learn_r ? S_LCHK : S_G1;
        S_LCHK: begin
          st_r <= (qs_r && (abs64(res_nxt) >= SMALL_005)) ? S_LC1 : S_PH;
        end
        S_LC1: st_r <= S_LC2;
        S_LC2: st_r <= S_LC3;
        S_LC3: st_r <= S_LC4;
        S_LC4: st_r <= S_LS1;
        S_LS1: st_r <= S_LS2;
        S_LS2: st_r <= S_LS3;
        S_LS3: st_r <= S_LS4;
        S_LS4: begin
          cos_r <= 32'(sat(64'(cos_r) + 64'(dc_r), lim64));
          sin_r <= 32'(sat(64'(sin_r) + ((p_r + HALF_R) >>> RATE_BITS), lim64));
          st_r  <= S_PH;
        end
        S_G1: st_r <= S_G2;
        S_G2: st_r <= S_G3;
        S_G3: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/adaptive_gravity_compensation_unit.sv
// Top level of the adaptive gravity compensation unit: ports, configuration, front and back.
// The path from an accepted input beat to its result beat is shortest when the torque limit is
// not positive, then grows from no learning step tried to a step that the quasi-static check
// turns down to a learning step taken. The back end's sequencer works on one item at a time,
// runs every product through one shared multiplier and takes the next item only when done;
// a two-entry queue lets input beats land early.
// Reset (synchronous, active low) clears the learned coefficients, the position reference,
// the timestamp history and the queue, and loads the reset values of both registers.
module adaptive_gravity_compensation_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_fresh,
  input  logic        [31:0] in_feedback_time,
  input  logic signed [31:0] in_actual_angle,
  input  logic signed [31:0] in_actual_speed,
  input  logic signed [31:0] in_measured_torque,
  input  logic signed [31:0] in_desired_angle,
  input  logic signed [31:0] in_desired_speed,
  input  logic signed [31:0] in_request_torque,
  input  logic signed [31:0] in_limit_torque,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_torque,
  output logic signed [31:0] out_gravity_part,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [30:0] cfg_wdata
);
  import agc_pkg::*;

  item_t       in_item;
  qitem_t      q_head;
  logic        q_valid;
  logic        q_pop;
  logic [16:0] learning_rate_r;
  logic [30:0] model_limit_r;

  // The whole input beat travels as one struct.
  always_comb begin
    in_item.fresh           = in_fresh;
    in_item.feedback_time   = in_feedback_time;
    in_item.actual_angle    = in_actual_angle;
    in_item.actual_speed    = in_actual_speed;
    in_item.measured_torque = in_measured_torque;
    in_item.desired_angle   = in_desired_angle;
    in_item.desired_speed   = in_desired_speed;
    in_item.request_torque  = in_request_torque;
    in_item.limit_torque    = in_limit_torque;
  end

  // Configuration registers. The gain is unsigned Q1.16, the model limit unsigned Q15.16.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r <= 17'd655;
      model_limit_r   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: learning_rate_r <= cfg_wdata[16:0];
        REG_MODEL_LIMIT:   model_limit_r   <= cfg_wdata;
        default:           model_limit_r   <= model_limit_r;
      endcase
    end
  end

  // The front end takes beats while the back end is busy with an earlier item.
  agc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  // The back end learns the coefficients and evaluates the clamped model; its output
  // register holds a finished result while the next item is already being worked on.
  agc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_head        (q_head),
    .learning_rate (learning_rate_r),
    .model_limit   (model_limit_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive     (out_drive_torque),
    .out_grav      (out_gravity_part)
  );

endmodule
